FILE: hw/rtl/cia_pkg.sv
// shared constants, codes and command types of the connection id allocator
package cia_pkg;

   localparam int ID_W  = 10;
   localparam int CNT_W = 11;
   localparam int OP_W  = 2;
   localparam int ST_W  = 2;

   // number of identifiers held in the stack and the active map
   localparam logic [CNT_W-1:0] MAX_IDS = 11'd1024;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd1024;
   localparam logic [CNT_W-1:0] FRESH_FIRST = 11'd1;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD       = 2'd2;

   typedef struct packed {
      logic            push;
      logic            pop;
      logic [ID_W-1:0] push_id;
   } stack_cmd_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] addr;
      logic            value;
   } map_wr_type;

endpackage

FILE: hw/rtl/cia_req_if.sv
// request channel: operation and identifier
interface cia_req_if import cia_pkg::*;;
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] operation;
   logic [ID_W-1:0] conn_id;

   modport source (output valid, output operation, output conn_id, input ready);
   modport sink   (input valid, input operation, input conn_id, output ready);
endinterface

FILE: hw/rtl/cia_rsp_if.sv
// response channel: status and granted identifier
interface cia_rsp_if import cia_pkg::*;;
   logic            valid;
   logic            ready;
   logic [ST_W-1:0] status;
   logic [ID_W-1:0] granted_id;

   modport source (output valid, output status, output granted_id, input ready);
   modport sink   (input valid, input status, input granted_id, output ready);
endinterface

FILE: hw/rtl/connection_id_allocator.sv
// connection id allocator top level: control sequencer around stack and map memories
//
// usage
//   req_if carries one request beat: operation (allocate, release, lookup) and
//   conn_id. rsp_if returns exactly one beat per request, in order: status and
//   granted_id. csr_wr_en/csr_wr_data load client_limit (11 bits), write only
//   while the block is idle.
// request sequence
//   the accept edge launches the synchronous reads of the free stack (top
//   entry) and the active map (conn_id); the commit edge in S_EXEC applies
//   the decision, writes both memories back and loads the response register.
//   one request is in flight at a time: a new request is not accepted until
//   the last one has committed.
// reset
//   synchronous, active high. counters and client_limit return to their reset
//   values, then the active map is swept to zero one entry a cycle: req_if.ready
//   stays low until the sweep has cleared every entry of the map.
// stalls
//   the response sits in an output register; while it waits for rsp_if.ready
//   the next request is still accepted and read. its commit waits until the
//   output register is free, so nothing is lost or overwritten.
module connection_id_allocator import cia_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   cia_req_if.sink          req_if,
   cia_rsp_if.source        rsp_if,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type        state_ff;
   logic [OP_W-1:0]  op_ff;
   logic [ID_W-1:0]  id_ff;
   logic [CNT_W-1:0] limit_ff;
   logic [CNT_W-1:0] fresh_ff;
   logic [CNT_W-1:0] fresh_in;
   logic             rsp_valid_ff;
   logic [ST_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]  rsp_granted_ff;

   logic             accept;
   logic             slot_free;
   logic             commit;
   logic             map_cleared;
   logic             map_bit;
   logic [ID_W-1:0]  stack_top;
   logic [CNT_W-1:0] free_count;

   logic [ST_W-1:0]  status_in;
   logic [ID_W-1:0]  granted_in;
   stack_cmd_type    stack_dec;
   stack_cmd_type    stack_cmd;
   map_wr_type       map_dec;
   map_wr_type       map_wr;

   assign req_if.ready = (state_ff == S_IDLE) && map_cleared;
   assign accept       = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign commit       = (state_ff == S_EXEC) && slot_free;

   cia_free_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .cmd    (stack_cmd),
      .top_id (stack_top),
      .count  (free_count)
   );

   cia_active_map u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_if.conn_id),
      .wr      (map_wr),
      .rd_bit  (map_bit),
      .cleared (map_cleared)
   );

   // decision on the read data of the request in flight
   always_comb begin
      status_in  = ST_BAD;
      granted_in = '0;
      fresh_in   = fresh_ff;
      stack_dec  = '0;
      map_dec    = '0;
      case (op_ff)
         OP_ALLOC: begin
            if (free_count != '0 && free_count <= MAX_IDS) begin
               // reuse the most recently released id
               stack_dec.pop = 1'b1;
               granted_in    = stack_top;
               map_dec       = '{en: 1'b1, addr: stack_top, value: 1'b1};
               status_in     = ST_OK;
            end else if (fresh_ff < limit_ff && fresh_ff < MAX_IDS) begin
               // mint a fresh id
               granted_in = fresh_ff[ID_W-1:0];
               map_dec    = '{en: 1'b1, addr: fresh_ff[ID_W-1:0], value: 1'b1};
               fresh_in   = fresh_ff + 11'd1;
               status_in  = ST_OK;
            end else begin
               status_in = ST_EXHAUSTED;
            end
         end
         OP_RELEASE: begin
            if (id_ff != '0 && map_bit) begin
               map_dec           = '{en: 1'b1, addr: id_ff, value: 1'b0};
               stack_dec.push    = free_count < MAX_IDS;
               stack_dec.push_id = id_ff;
               status_in         = ST_OK;
            end
         end
         OP_LOOKUP: begin
            if (id_ff != '0 && map_bit) begin
               status_in = ST_OK;
            end
         end
         default: begin
            status_in = ST_BAD;
         end
      endcase
   end

   // memory writes only on the commit edge
   always_comb begin
      stack_cmd         = stack_dec;
      stack_cmd.push    = stack_dec.push && commit;
      stack_cmd.pop     = stack_dec.pop && commit;
      map_wr            = map_dec;
      map_wr.en         = map_dec.en && commit;
   end

   // sequencer, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         fresh_ff     <= FRESH_FIRST;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
               end
               if (rsp_if.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (commit) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  fresh_ff     <= fresh_in;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (accept) begin
         op_ff <= req_if.operation;
         id_ff <= req_if.conn_id;
      end
      if (commit) begin
         rsp_status_ff  <= status_in;
         rsp_granted_ff <= granted_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.granted_id = rsp_granted_ff;

endmodule

FILE: hw/rtl/cia_free_stack.sv
// lifo free stack: identifier memory with its fill count
module cia_free_stack import cia_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  stack_cmd_type        cmd,
   output logic [ID_W-1:0]      top_id,
   output logic [CNT_W-1:0]     count
);

   logic [ID_W-1:0]  mem [0:MAX_IDS-1];
   logic [ID_W-1:0]  rd_data_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] top_addr;

   assign top_addr = count_ff - 11'd1;

   always_comb begin
      count_in = count_ff;
      if (cmd.pop) begin
         count_in = count_ff - 11'd1;
      end else if (cmd.push) begin
         count_in = count_ff + 11'd1;
      end
   end

   // top of stack read, held until the next request
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[top_addr[ID_W-1:0]];
      end
      if (cmd.push) begin
         mem[count_ff[ID_W-1:0]] <= cmd.push_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top_id = rd_data_ff;
   assign count  = count_ff;

endmodule

FILE: hw/rtl/cia_active_map.sv
// active map: one bit per identifier, swept to zero after reset
module cia_active_map import cia_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [ID_W-1:0] rd_addr,
   input  map_wr_type      wr,
   output logic            rd_bit,
   output logic            cleared
);

   logic            mem [0:MAX_IDS-1];
   logic            rd_data_ff;
   logic [ID_W-1:0] sweep_ff;
   logic            done_ff;
   logic            wen;
   logic [ID_W-1:0] waddr;
   logic            wdata;

   always_comb begin
      if (!done_ff) begin
         wen   = 1'b1;
         waddr = sweep_ff;
         wdata = 1'b0;
      end else begin
         wen   = wr.en;
         waddr = wr.addr;
         wdata = wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   // clearing sweep, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         done_ff  <= 1'b0;
      end else if (!done_ff) begin
         sweep_ff <= sweep_ff + 10'd1;
         if (sweep_ff == ID_W'(MAX_IDS - 11'd1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   assign rd_bit  = rd_data_ff;
   assign cleared = done_ff;

endmodule

FILE: hw/rtl/cia_checker.sv
// port-level checks of the connection id allocator and their bind
module cia_checker import cia_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [ST_W-1:0] rsp_status,
   input logic [ID_W-1:0] rsp_granted_id
);

   // no response beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request in flight: ready drops after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while one is in flight");

   // only the defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EXHAUSTED ||
                     rsp_status == ST_BAD))
      else $error("undefined status code");

   // a failed request grants nothing
   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_granted_id == '0)
      else $error("id granted with error status");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_granted_id)))
      else $error("stalled response changed");

endmodule

bind connection_id_allocator cia_checker u_cia_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_granted_id (rsp_if.granted_id)
);
